// ----- rtl/qcv_pkg.sv -----
// Shared types and constants for the quadrature counter velocity unit.
package qcv_pkg;

   localparam logic [1:0] REQ_EDGE_A = 2'd0;
   localparam logic [1:0] REQ_EDGE_B = 2'd1;
   localparam logic [1:0] REQ_TICK   = 2'd2;

   localparam int NUM_W  = 60;
   localparam int DEN_W  = 51;
   localparam int TERM_W = 32;
   localparam int QUO_W  = 32;

   localparam logic [12:0] RAD_SCALE = 13'd6280;
   localparam logic [15:0] EPR_RESET = 16'd3072;
   localparam logic [TERM_W-1:0] TERM_MAX = 32'h7FFF_FFFF;
   localparam logic [TERM_W-1:0] TERM_MIN = 32'h8000_0000;

   typedef struct packed {
      logic              done;
      logic [TERM_W-1:0] term;
   } div_stat_type;

   typedef struct packed {
      logic              done;
      logic [TERM_W-1:0] speed;
   } ring_stat_type;

endpackage

// ----- rtl/qcv_term_div.sv -----
// Restoring divider, one quotient bit per cycle, producing a saturated signed term.
module qcv_term_div (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [qcv_pkg::NUM_W-1:0]   num,
   input  logic [qcv_pkg::DEN_W-1:0]   den,
   input  logic                        neg,
   output qcv_pkg::div_stat_type       stat
);

   localparam int DW = qcv_pkg::DEN_W + qcv_pkg::QUO_W - 1;

   logic [qcv_pkg::NUM_W-1:0] rem_ff;
   logic [DW-1:0]             dsr_ff;
   logic [qcv_pkg::QUO_W-1:0] quo_ff;
   logic                      neg_ff;
   logic [4:0]                cnt_ff;
   logic                      busy_ff;
   logic                      done_ff;

   logic [DW-1:0]             rem_ext;
   logic [qcv_pkg::NUM_W-1:0] diff;
   logic                      ge;

   always_comb begin
      rem_ext = DW'(rem_ff);
      ge      = rem_ext >= dsr_ff;
      diff    = qcv_pkg::NUM_W'(rem_ext - dsr_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= 5'd0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= 5'(qcv_pkg::QUO_W - 1);
         end else if (busy_ff) begin
            if (cnt_ff == 5'd0) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end else begin
               cnt_ff <= cnt_ff - 5'd1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= num;
         dsr_ff <= {den, {(qcv_pkg::QUO_W-1){1'b0}}};
         quo_ff <= '0;
         neg_ff <= neg;
      end else if (busy_ff) begin
         if (ge) begin
            rem_ff <= diff;
         end
         quo_ff <= {quo_ff[qcv_pkg::QUO_W-2:0], ge};
         dsr_ff <= dsr_ff >> 1;
      end
   end

   // top quotient bit set means |q| >= 2^31: saturate
   always_comb begin
      stat.done = done_ff;
      if (quo_ff[qcv_pkg::QUO_W-1]) begin
         stat.term = neg_ff ? qcv_pkg::TERM_MIN : qcv_pkg::TERM_MAX;
      end else begin
         stat.term = neg_ff ? (32'd0 - quo_ff) : quo_ff;
      end
   end

endmodule

// ----- rtl/qcv_ring_avg.sv -----
// Ring of velocity terms with a sequential saturating sum, one entry per cycle.
module qcv_ring_avg #(
   parameter int AVG_TAPS = 5
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        wr_en,
   input  logic [qcv_pkg::TERM_W-1:0]  wr_term,
   input  logic                        sum_start,
   output qcv_pkg::ring_stat_type      stat
);

   localparam int PW = (AVG_TAPS > 1) ? $clog2(AVG_TAPS) : 1;
   localparam int SW = qcv_pkg::TERM_W + PW + 1;
   localparam logic [PW-1:0] LAST = PW'(AVG_TAPS - 1);

   logic [qcv_pkg::TERM_W-1:0] ring_ff [AVG_TAPS];
   logic [PW-1:0]              pos_ff;
   logic [PW-1:0]              idx_ff;
   logic signed [SW-1:0]       acc_ff;
   logic                       busy_ff;
   logic                       done_ff;
   logic [qcv_pkg::TERM_W-1:0] speed_ff;

   logic [qcv_pkg::TERM_W-1:0] entry;
   logic signed [SW-1:0]       acc_sum;
   logic                       fits;

   always_comb begin
      entry   = ring_ff[idx_ff];
      acc_sum = acc_ff + $signed({{(SW-qcv_pkg::TERM_W){entry[qcv_pkg::TERM_W-1]}}, entry});
      fits    = (&acc_sum[SW-1:qcv_pkg::TERM_W-1]) || ~(|acc_sum[SW-1:qcv_pkg::TERM_W-1]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < AVG_TAPS; k++) begin
            ring_ff[k] <= '0;
         end
         pos_ff   <= '0;
         idx_ff   <= '0;
         acc_ff   <= '0;
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         speed_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (wr_en) begin
            ring_ff[pos_ff] <= wr_term;
            pos_ff          <= (pos_ff == LAST) ? '0 : pos_ff + PW'(1);
         end
         if (sum_start) begin
            busy_ff <= 1'b1;
            idx_ff  <= '0;
            acc_ff  <= '0;
         end else if (busy_ff) begin
            acc_ff <= acc_sum;
            if (idx_ff == LAST) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
               if (fits) begin
                  speed_ff <= acc_sum[qcv_pkg::TERM_W-1:0];
               end else begin
                  speed_ff <= acc_sum[SW-1] ? qcv_pkg::TERM_MIN : qcv_pkg::TERM_MAX;
               end
            end else begin
               idx_ff <= idx_ff + PW'(1);
            end
         end
      end
   end

   assign stat.done  = done_ff;
   assign stat.speed = speed_ff;

endmodule

// ----- rtl/quadrature_counter_velocity_unit.sv -----
// Top level: x4 quadrature position counter with averaged velocity estimate.
//
//   channel   ports                          direction   handshake
//   req       req_type/a_level/b_level/time  in          req_valid, req_stall
//   rsp       position/velocity/updated      out         rsp_valid, rsp_stall
//   csr       csr_write_data (events/rev)    in          csr_write_enable
//
// Edge and unused items: accept moves to S_OUT, which loads the output register.
// Update ticks: S_MUL, S_SCALE, S_DIV, S_RSTART and S_SUM, paced by the 32-step divider and
// the ring sum that reads one entry per cycle.
// One item at a time; req_stall is high until the result sits in the output register.
// Synchronous active-high reset clears position, history, ring and velocity.
module quadrature_counter_velocity_unit #(
   parameter int AVG_TAPS = 5
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [1:0]         req_type,
   input  logic               req_a_level,
   input  logic               req_b_level,
   input  logic [31:0]        req_time_ms,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [31:0] rsp_position,
   output logic signed [31:0] rsp_velocity,
   output logic               rsp_velocity_updated,
   input  logic               csr_write_enable,
   input  logic [15:0]        csr_write_data
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_OUT,
      S_MUL,
      S_SCALE,
      S_DIV,
      S_RSTART,
      S_SUM
   } state_type;

   state_type state_ff, state_in;

   logic [31:0]                count_ff, count_in;
   logic [31:0]                last_count_ff, last_count_in;
   logic [31:0]                last_time_ff, last_time_in;
   logic                       first_ff, first_in;
   logic [15:0]                epr_ff, epr_in;
   logic [31:0]                mag_ff, mag_in;
   logic                       neg_ff, neg_in;
   logic [31:0]                dt_ff, dt_in;
   logic [qcv_pkg::NUM_W-1:0]  num_ff, num_in;
   logic [47:0]                prod_ff, prod_in;
   logic [31:0]                speed_ff, speed_in;
   logic                       upd_ff, upd_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [31:0]                rsp_pos_ff, rsp_pos_in;
   logic [31:0]                rsp_vel_ff, rsp_vel_in;
   logic                       rsp_upd_ff, rsp_upd_in;

   logic [31:0]                dcount;
   logic [31:0]                dt_raw;
   logic [15:0]                epr_eff;
   logic [43:0]                mul_rad;
   logic [qcv_pkg::DEN_W-1:0]  den;
   logic                       accept;

   qcv_pkg::div_stat_type      div_stat;
   qcv_pkg::ring_stat_type     ring_stat;

   qcv_term_div u_div (
      .clock (clock),
      .reset (reset),
      .start (state_ff == S_SCALE),
      .num   (num_ff),
      .den   (den),
      .neg   (neg_ff),
      .stat  (div_stat)
   );

   qcv_ring_avg #(
      .AVG_TAPS (AVG_TAPS)
   ) u_ring (
      .clock     (clock),
      .reset     (reset),
      .wr_en     ((state_ff == S_DIV) && div_stat.done),
      .wr_term   (div_stat.term),
      .sum_start (state_ff == S_RSTART),
      .stat      (ring_stat)
   );

   always_comb begin
      accept  = req_valid && (state_ff == S_IDLE);
      dcount  = count_ff - last_count_ff;
      dt_raw  = first_ff ? 32'd1 : (req_time_ms - last_time_ff);
      epr_eff = (epr_ff == 16'd0) ? 16'd1 : epr_ff;
      mul_rad = 44'(mag_ff) * 44'(qcv_pkg::RAD_SCALE);
      den     = qcv_pkg::DEN_W'(prod_ff) + (qcv_pkg::DEN_W'(prod_ff) << 2);

      state_in      = state_ff;
      count_in      = count_ff;
      last_count_in = last_count_ff;
      last_time_in  = last_time_ff;
      first_in      = first_ff;
      epr_in        = epr_ff;
      mag_in        = mag_ff;
      neg_in        = neg_ff;
      dt_in         = dt_ff;
      num_in        = num_ff;
      prod_in       = prod_ff;
      speed_in      = speed_ff;
      upd_in        = upd_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_pos_in    = rsp_pos_ff;
      rsp_vel_in    = rsp_vel_ff;
      rsp_upd_in    = rsp_upd_ff;

      if (csr_write_enable) begin
         epr_in = csr_write_data;
      end
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               upd_in   = 1'b0;
               state_in = S_OUT;
               unique case (req_type)
                  qcv_pkg::REQ_EDGE_A: begin
                     count_in = (req_a_level ^ req_b_level) ? count_ff + 32'd1
                                                            : count_ff - 32'd1;
                  end
                  qcv_pkg::REQ_EDGE_B: begin
                     count_in = (req_a_level ^ req_b_level) ? count_ff - 32'd1
                                                            : count_ff + 32'd1;
                  end
                  qcv_pkg::REQ_TICK: begin
                     neg_in        = dcount[31];
                     mag_in        = dcount[31] ? (32'd0 - dcount) : dcount;
                     dt_in         = (dt_raw == 32'd0) ? 32'd1 : dt_raw;
                     last_count_in = count_ff;
                     last_time_in  = req_time_ms;
                     first_in      = 1'b0;
                     upd_in        = 1'b1;
                     state_in      = S_MUL;
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_MUL: begin
            num_in   = {mul_rad, 16'd0};
            prod_in  = 48'(dt_ff) * 48'(epr_eff);
            state_in = S_SCALE;
         end
         S_SCALE: begin
            state_in = S_DIV;
         end
         S_DIV: begin
            if (div_stat.done) begin
               state_in = S_RSTART;
            end
         end
         S_RSTART: begin
            state_in = S_SUM;
         end
         S_SUM: begin
            if (ring_stat.done) begin
               speed_in = ring_stat.speed;
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_pos_in   = count_ff;
               rsp_vel_in   = speed_ff;
               rsp_upd_in   = upd_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         count_ff      <= '0;
         last_count_ff <= '0;
         last_time_ff  <= '0;
         first_ff      <= 1'b1;
         epr_ff        <= qcv_pkg::EPR_RESET;
         speed_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         last_count_ff <= last_count_in;
         last_time_ff  <= last_time_in;
         first_ff      <= first_in;
         epr_ff        <= epr_in;
         speed_ff      <= speed_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      mag_ff     <= mag_in;
      neg_ff     <= neg_in;
      dt_ff      <= dt_in;
      num_ff     <= num_in;
      prod_ff    <= prod_in;
      upd_ff     <= upd_in;
      rsp_pos_ff <= rsp_pos_in;
      rsp_vel_ff <= rsp_vel_in;
      rsp_upd_ff <= rsp_upd_in;
   end

   assign req_stall            = (state_ff != S_IDLE);
   assign rsp_valid            = rsp_valid_ff;
   assign rsp_position         = $signed(rsp_pos_ff);
   assign rsp_velocity         = $signed(rsp_vel_ff);
   assign rsp_velocity_updated = rsp_upd_ff;

   a_edge_step: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall &&
       (req_type == qcv_pkg::REQ_EDGE_A || req_type == qcv_pkg::REQ_EDGE_B))
      |=> (count_ff == $past(count_ff) + 32'd1) || (count_ff == $past(count_ff) - 32'd1))
      else $error("edge beat did not move position by one");

   a_div_done: assert property (@(posedge clock) disable iff (reset)
      div_stat.done |-> (state_ff == S_DIV))
      else $error("divider finished outside the divide phase");

   a_ring_done: assert property (@(posedge clock) disable iff (reset)
      ring_stat.done |-> (state_ff == S_SUM))
      else $error("ring sum finished outside the sum phase");

endmodule
